// ===== design/sbus_fd_pkg.sv =====
// Shared constants, types and control structs for the S-BUS frame decoder.
// No dependencies; every other design file imports this package.
`default_nettype none

package sbus_fd_pkg;

  // Frame layout
  localparam logic [7:0] START_MARK    = 8'h0F;
  localparam logic [7:0] END_MARK      = 8'h00;
  localparam int         FRAME_BYTES   = 25;
  localparam int         PAYLOAD_BYTES = 22;
  localparam int         FAILSAFE_BIT  = 4;
  localparam int         VALUE_BITS    = 11;
  localparam int         NUM_CHANNELS  = 16;
  localparam int         PAYLOAD_BITS  = PAYLOAD_BYTES * 8;

  // Byte positions within a frame
  localparam logic [4:0] POS_START     = 5'd0;
  localparam logic [4:0] POS_LAST_DATA = 5'(PAYLOAD_BYTES);
  localparam logic [4:0] POS_FLAGS     = 5'(PAYLOAD_BYTES + 1);
  localparam logic [4:0] POS_END       = 5'(FRAME_BYTES - 1);

  localparam logic [3:0] LAST_CHANNEL  = 4'(NUM_CHANNELS - 1);

  typedef logic [4:0]  pos_t;
  typedef logic [3:0]  chan_t;
  typedef logic [10:0] value_t;

  // Controller to datapath
  typedef struct packed {
    logic byte_shift;   // push received payload byte into the shift line
    logic flags_load;   // capture failsafe state from the flags byte
    logic chan_shift;   // drop the channel just delivered
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic is_end;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/sbus_fd_if.sv =====
// Valid/ready channel interfaces for the frame decoder's byte input and
// channel result output. Depends on sbus_fd_pkg.
`default_nettype none

interface sbus_fd_in_if
  import sbus_fd_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbus_fd_out_if
  import sbus_fd_pkg::*;
  ();
  logic   valid;
  logic   ready;
  chan_t  channel_index;
  value_t channel_value;
  logic   link_active;
  logic   last;

  modport source (output valid, output channel_index, output channel_value,
                  output link_active, output last, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input link_active, input last, output ready);
endinterface

`default_nettype wire

// ===== design/sbus_fd_datapath.sv =====
// Datapath: payload shift line, failsafe flag and byte compares.
// Depends on sbus_fd_pkg; driven by sbus_fd_ctrl commands.
`default_nettype none

module sbus_fd_datapath
  import sbus_fd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [7:0] in_byte,
  input  wire dp_cmd_t    cmd,
  output dp_stat_t        stat,
  output value_t          chan_value,
  output logic            link_active
);

  logic [PAYLOAD_BITS-1:0] payload_r;
  logic [PAYLOAD_BITS-1:0] payload_nxt;
  logic                    link_r;
  logic                    link_nxt;

  // Bytes enter at the top, so byte 1 ends at the bottom: LSB-first stream.
  // Delivering a channel shifts the next one down to bit 0.
  always_comb begin
    payload_nxt = payload_r;
    if (cmd.byte_shift) begin
      payload_nxt = {in_byte, payload_r[PAYLOAD_BITS-1:8]};
    end else if (cmd.chan_shift) begin
      payload_nxt = payload_r >> VALUE_BITS;
    end
  end

  // Link is active when the failsafe bit is clear
  assign link_nxt = cmd.flags_load ? ~in_byte[FAILSAFE_BIT] : link_r;

  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
    link_r    <= link_nxt;
  end

  assign stat.is_start = (in_byte == START_MARK);
  assign stat.is_end   = (in_byte == END_MARK);
  assign chan_value    = payload_r[VALUE_BITS-1:0];
  assign link_active   = link_r;

endmodule

`default_nettype wire

// ===== design/sbus_fd_ctrl.sv =====
// Controller: frame position tracking, start/end checks and result sequencing.
// Depends on sbus_fd_pkg; commands sbus_fd_datapath.
`default_nettype none

module sbus_fd_ctrl
  import sbus_fd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output chan_t         chan_idx,
  output logic          chan_last
);

  localparam logic ST_RECV = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic  state_r, state_nxt;
  pos_t  pos_r, pos_nxt;
  chan_t ch_r, ch_nxt;
  logic  in_fire, out_fire;

  assign in_ready  = (state_r == ST_RECV);
  assign out_valid = (state_r == ST_EMIT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign chan_idx  = ch_r;
  assign chan_last = (ch_r == LAST_CHANNEL);

  // Next state, position and channel counter
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    ch_nxt         = ch_r;
    cmd.byte_shift = 1'b0;
    cmd.flags_load = 1'b0;
    cmd.chan_shift = 1'b0;
    unique case (state_r)
      ST_RECV: begin
        if (in_fire) begin
          priority if (pos_r == POS_START) begin
            if (stat.is_start) pos_nxt = pos_r + 5'd1;
          end else if (pos_r < POS_END) begin
            cmd.byte_shift = (pos_r <= POS_LAST_DATA);
            cmd.flags_load = (pos_r == POS_FLAGS);
            pos_nxt        = pos_r + 5'd1;
          end else begin
            // end position: bad closing byte drops the frame
            pos_nxt = POS_START;
            if (stat.is_end) begin
              state_nxt = ST_EMIT;
              ch_nxt    = '0;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          cmd.chan_shift = 1'b1;
          if (chan_last) begin
            state_nxt = ST_RECV;
          end else begin
            ch_nxt = ch_r + 4'd1;
          end
        end
      end
      default: state_nxt = ST_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RECV;
      pos_r   <= POS_START;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // Position never runs past the end byte
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_END)
    else $error("frame position out of range");

  // No frame is in progress while results are going out
  a_emit_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pos_r == POS_START))
    else $error("position moved during result burst");

  // A good end byte starts the burst at channel 0
  a_good_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pos_r == POS_END && stat.is_end) |=> (out_valid && ch_r == '0))
    else $error("good frame did not start result burst");

  // After the last channel beat the block takes bytes again
  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && chan_last) |=> in_ready)
    else $error("block did not return to receive after last channel");

endmodule

`default_nettype wire

// ===== design/sbus_frame_decoder.sv =====
// S-BUS frame decoder: takes received bytes one beat per cycle, checks the
// start and end bytes, then delivers one result beat per channel. Each
// channel's 11-bit value comes LSB-first from the 22 payload bytes and
// carries the link-active flag (inverse of failsafe bit 4 of the flags
// byte) and a last marker on the final channel. Depends on sbus_fd_pkg,
// sbus_fd_if, sbus_fd_ctrl and sbus_fd_datapath.
// A good frame's closing byte starts a burst of 16 result beats, one per
// cycle while out_ch.ready is high; the payload shift line moves down one
// channel per beat, and the input is held off until the last beat is
// taken, so a frame costs 25 byte beats plus 16 result beats. No clearing
// pass is needed after reset.
`default_nettype none

module sbus_frame_decoder
  import sbus_fd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  sbus_fd_in_if.sink    in_ch,
  sbus_fd_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  chan_t    chan_idx;
  logic     chan_last;
  value_t   chan_value;
  logic     link_active;
  logic     in_ready;
  logic     out_valid;

  sbus_fd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd),
    .chan_idx  (chan_idx),
    .chan_last (chan_last)
  );

  sbus_fd_datapath u_dp (
    .clk         (clk),
    .in_byte     (in_ch.rx_byte),
    .cmd         (cmd),
    .stat        (stat),
    .chan_value  (chan_value),
    .link_active (link_active)
  );

  // Channel ports
  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.channel_index = chan_idx;
  assign out_ch.channel_value = chan_value;
  assign out_ch.link_active   = link_active;
  assign out_ch.last          = chan_last;

endmodule

`default_nettype wire

// ===== tb/sbus_frame_decoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sbus_frame_decoder: random byte streams of S-BUS
// frames, a frame-level predictor and a result scoreboard with bursty stalls.
// Depends on sbus_fd_pkg, sbus_fd_if and the decoder itself.

module sbus_frame_decoder_tb;
  import sbus_fd_pkg::*;

  typedef logic [(PAYLOAD_BYTES + 1) * 8 - 1:0] frame_body_t;

  typedef struct packed {
    chan_t  index;
    value_t value;
    logic   active;
    logic   last;
  } channel_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Driven copies of the block's inputs, known from time zero
  logic       drv_valid  = 1'b0;
  logic [7:0] drv_byte   = 8'h00;
  logic       sink_ready = 1'b0;

  sbus_fd_in_if  in_bus ();
  sbus_fd_out_if out_bus ();

  assign in_bus.valid   = drv_valid;
  assign in_bus.rx_byte = drv_byte;
  assign out_bus.ready  = sink_ready;

  sbus_frame_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard storage
  logic [7:0]    pending_bytes[$];
  channel_beat_t expected_channels[$];

  // Predictor state
  pos_t       frame_pos;
  logic [7:0] frame_store [PAYLOAD_BYTES + 1];

  int mismatches       = 0;
  int bytes_accepted   = 0;
  int frames_decoded   = 0;
  int frames_dropped   = 0;
  int channels_checked = 0;
  int frame_bytes_queued = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Track frame position per accepted byte; a good end byte yields one
  // beat per channel, unpacked LSB-first from the payload bytes.
  task automatic predict_byte(input logic [7:0] rx);
    logic [PAYLOAD_BITS-1:0] payload;
    channel_beat_t beat;
    if (frame_pos == POS_START) begin
      if (rx == START_MARK) frame_pos = POS_START + 5'd1;
    end else if (frame_pos < POS_END) begin
      frame_store[frame_pos - 5'd1] = rx;
      frame_pos = frame_pos + 5'd1;
    end else begin
      // end position: bad end byte drops the frame, never restarts it
      frame_pos = POS_START;
      if (rx != END_MARK) begin
        frames_dropped++;
      end else begin
        frames_decoded++;
        for (int j = 0; j < PAYLOAD_BYTES; j++) payload[8*j +: 8] = frame_store[j];
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
          beat.index  = chan_t'(ch);
          beat.value  = payload[VALUE_BITS*ch +: VALUE_BITS];
          beat.active = ~frame_store[PAYLOAD_BYTES][FAILSAFE_BIT];
          beat.last   = (ch == NUM_CHANNELS - 1);
          expected_channels.push_back(beat);
        end
      end
    end
  endtask

  task automatic queue_frame(input frame_body_t body, input logic [7:0] tail);
    pending_bytes.push_back(START_MARK);
    for (int j = 0; j <= PAYLOAD_BYTES; j++) pending_bytes.push_back(body[8*j +: 8]);
    pending_bytes.push_back(tail);
    frame_bytes_queued += FRAME_BYTES;
  endtask

  function automatic frame_body_t random_body();
    frame_body_t body;
    for (int j = 0; j <= PAYLOAD_BYTES; j++) body[8*j +: 8] = 8'($urandom);
    return body;
  endfunction

  // Byte driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int idle_left  = 0;

  always @(posedge clk) begin : drive_bytes
    logic fired;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      fired = drv_valid && in_bus.ready;
      if (fired) begin
        predict_byte(drv_byte);
        void'(pending_bytes.pop_front());
        bytes_accepted++;
        if (burst_left > 0) burst_left--;
      end
      if (!(drv_valid && !fired)) begin
        if (burst_left == 0 && idle_left == 0) begin
          burst_left = $urandom_range(1, 40);
          idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (idle_left > 0) begin
          idle_left--;
          drv_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          drv_valid <= 1'b1;
          drv_byte  <= pending_bytes[0];
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: ready pattern cycles through four modes
  logic [9:0] stall_cycle = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready  <= 1'b0;
      stall_cycle <= '0;
    end else begin
      stall_cycle <= stall_cycle + 10'd1;
      case (stall_cycle[8:7])
        2'd0: sink_ready <= 1'b1;
        2'd1: sink_ready <= ($urandom_range(0, 3) != 0);
        2'd2: sink_ready <= (stall_cycle[2:0] < 3'd5);
        default: sink_ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Result checker: each accepted beat against the oldest expectation
  always @(posedge clk) begin : check_results
    channel_beat_t want;
    if (rst_n && out_bus.valid && sink_ready) begin
      if (expected_channels.size() == 0) begin
        report_mismatch($sformatf("unexpected beat ch %0d value %0d",
                                  out_bus.channel_index, out_bus.channel_value));
      end else begin
        want = expected_channels.pop_front();
        channels_checked++;
        if (out_bus.channel_index !== want.index)
          report_mismatch($sformatf("channel_index %0d, want %0d",
                                    out_bus.channel_index, want.index));
        if (out_bus.channel_value !== want.value)
          report_mismatch($sformatf("ch %0d channel_value %0d, want %0d",
                                    want.index, out_bus.channel_value, want.value));
        if (out_bus.link_active !== want.active)
          report_mismatch($sformatf("ch %0d link_active %b, want %b",
                                    want.index, out_bus.link_active, want.active));
        if (out_bus.last !== want.last)
          report_mismatch($sformatf("ch %0d last %b, want %b",
                                    want.index, out_bus.last, want.last));
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : run_sequence
    frame_body_t body;
    int pick;
    int count;
    logic [7:0] noise;

    frame_pos = POS_START;

    // Directed: stray bytes while searching, all-ones payload with link up,
    // zero payload in failsafe closed by a start byte (dropped, not a new
    // start), then the same zero frame closed properly.
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(END_MARK);
    pending_bytes.push_back(8'h0E);
    body = '1;
    body[8*PAYLOAD_BYTES + FAILSAFE_BIT] = 1'b0;
    queue_frame(body, END_MARK);
    body = '0;
    body[8*PAYLOAD_BYTES + FAILSAFE_BIT] = 1'b1;
    queue_frame(body, START_MARK);
    queue_frame(body, END_MARK);

    // Random: mostly good frames, some bad ends, noise and cut-off frames
    while (frame_bytes_queued < 450) begin
      pick = $urandom_range(0, 9);
      body = random_body();
      if (pick < 7) begin
        queue_frame(body, END_MARK);
      end else if (pick == 7) begin
        queue_frame(body, 8'($urandom_range(1, 255)));
      end else if (pick == 8) begin
        count = $urandom_range(1, 4);
        repeat (count) begin
          noise = 8'($urandom);
          if (noise == START_MARK) noise = ~noise;
          pending_bytes.push_back(noise);
        end
      end else begin
        count = $urandom_range(1, PAYLOAD_BYTES);
        pending_bytes.push_back(START_MARK);
        for (int j = 0; j < count; j++) pending_bytes.push_back(body[8*j +: 8]);
        frame_bytes_queued += count + 1;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || drv_valid) @(posedge clk);
    while (expected_channels.size() != 0) @(posedge clk);
    repeat (4 * NUM_CHANNELS) @(posedge clk);

    $display("Covered %0d input bytes: %0d frames decoded, %0d frames dropped at the end byte",
             bytes_accepted, frames_decoded, frames_dropped);
    $display("Checked %0d channel beats, %0d mismatches", channels_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d bytes and %0d beats outstanding",
             pending_bytes.size(), expected_channels.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
design/sbus_fd_pkg.sv
design/sbus_fd_if.sv
design/sbus_fd_datapath.sv
design/sbus_fd_ctrl.sv
design/sbus_frame_decoder.sv
tb/sbus_frame_decoder_tb.sv
